### src/pewb_pkg.sv
package pewb_pkg;

    // Fixed-point format: every quantity carries this many fraction bits.
    localparam int FRAC_BITS = 16;

    localparam int DT_W     = 17;
    localparam int MARGIN_W = 31;
    localparam int CFG_W    = 32;
    localparam int VOUT_W   = 24;

    // Internal velocity width: wide enough for plus or minus 100 in the fixed format.
    localparam int VEL_W = FRAC_BITS + 8;

    // Width of a rounded velocity times time step product.
    localparam int VDT_W = VEL_W + DT_W + 1 - FRAC_BITS;

    localparam longint ONE_L  = longint'(1) << FRAC_BITS;
    localparam longint HALF_L = longint'(1) << (FRAC_BITS - 1);
    localparam longint DRAG_L = (ONE_L * 9999 + 5000) / 10000;
    localparam longint DAMP_L = (ONE_L * 9 + 5) / 10;
    localparam longint VLIM_L = ONE_L * 100;

    localparam logic signed [FRAC_BITS+1:0] DRAG_C = (FRAC_BITS + 2)'(DRAG_L);
    localparam logic signed [FRAC_BITS+1:0] DAMP_C = (FRAC_BITS + 2)'(DAMP_L);
    localparam logic signed [VEL_W-1:0]     VLIM_P = VEL_W'(VLIM_L);
    localparam logic signed [VEL_W-1:0]     VLIM_N = VEL_W'(-VLIM_L);

    // Configuration register indexes.
    localparam logic [2:0] REG_TIME_STEP   = 3'd0;
    localparam logic [2:0] REG_WALL_MARGIN = 3'd1;
    localparam logic [2:0] REG_BOX_LOW_X   = 3'd2;
    localparam logic [2:0] REG_BOX_LOW_Y   = 3'd3;
    localparam logic [2:0] REG_BOX_HIGH_X  = 3'd4;
    localparam logic [2:0] REG_BOX_HIGH_Y  = 3'd5;

    // Configuration reset values.
    localparam logic [DT_W-1:0]         TIME_STEP_RST   = DT_W'(655);
    localparam logic [MARGIN_W-1:0]     WALL_MARGIN_RST = MARGIN_W'(65536);
    localparam logic signed [CFG_W-1:0] BOX_LOW_RST     = '0;
    localparam logic signed [CFG_W-1:0] BOX_HIGH_RST    = CFG_W'(6553600);

    typedef struct packed {
        logic [DT_W-1:0]         time_step;
        logic [MARGIN_W-1:0]     wall_margin;
        logic signed [CFG_W-1:0] box_low_x;
        logic signed [CFG_W-1:0] box_low_y;
        logic signed [CFG_W-1:0] box_high_x;
        logic signed [CFG_W-1:0] box_high_y;
    } pewb_cfg_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic               last_particle;
    } pewb_in_t;

    typedef struct packed {
        logic signed [31:0]       new_pos_x;
        logic signed [31:0]       new_pos_y;
        logic signed [VOUT_W-1:0] new_vel_x;
        logic signed [VOUT_W-1:0] new_vel_y;
        logic                     hit_wall;
        logic                     pass_done;
    } pewb_out_t;

    // Item after integration, handed to the wall stages.
    typedef struct packed {
        logic                    valid;
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic                    last;
    } pewb_mid_t;

    // Item after the wall reflections, handed to the nudge stages.
    typedef struct packed {
        logic                    valid;
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic                    hit;
        logic                    last;
    } pewb_wall_t;

    // Velocity times time step, rounded half up to the fixed format.
    function automatic logic signed [VDT_W-1:0] fx_vel_dt(
        input logic signed [VEL_W-1:0] v,
        input logic [DT_W-1:0]         dt
    );
        logic signed [VEL_W+DT_W:0] p;
        p = v * $signed({1'b0, dt});
        p = p + (VEL_W + DT_W + 1)'(HALF_L);
        return VDT_W'(p >>> FRAC_BITS);
    endfunction

    // Position plus a 33 bit wide sum, saturated to the signed 32 bit range.
    function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
        logic signed [31:0] r;
        if (s > 33'sh0_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (s < -33'sh0_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

### src/pewb_integrate.sv
module pewb_integrate (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  pewb_pkg::pewb_in_t  in_item,
    input  pewb_pkg::pewb_cfg_t cfg,
    output pewb_pkg::pewb_mid_t mid
);

    localparam int F       = pewb_pkg::FRAC_BITS;
    localparam int VW      = pewb_pkg::VEL_W;
    localparam int VD_P_W  = 32 + F + 2;
    localparam int VD_W    = VD_P_W - F;
    localparam int ADT_P_W = 32 + pewb_pkg::DT_W + 1;
    localparam int ADT_W   = ADT_P_W - F;
    localparam int SUM_W   = ((VD_W > ADT_W) ? VD_W : ADT_W) + 1;
    localparam int VDT_W   = pewb_pkg::VDT_W;

    typedef struct packed {
        logic                    valid;
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic signed [VD_W-1:0]  vd_x;
        logic signed [VD_W-1:0]  vd_y;
        logic signed [ADT_W-1:0] adt_x;
        logic signed [ADT_W-1:0] adt_y;
        logic                    last;
    } s1_t;

    typedef struct packed {
        logic                 valid;
        logic signed [31:0]   pos_x;
        logic signed [31:0]   pos_y;
        logic signed [VW-1:0] vel_x;
        logic signed [VW-1:0] vel_y;
        logic                 last;
    } s2_t;

    typedef struct packed {
        logic                    valid;
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic signed [VW-1:0]    vel_x;
        logic signed [VW-1:0]    vel_y;
        logic signed [VDT_W-1:0] vdt_x;
        logic signed [VDT_W-1:0] vdt_y;
        logic                    last;
    } s3_t;

    s1_t                 s1_reg, s1_next;
    s2_t                 s2_reg, s2_next;
    s3_t                 s3_reg, s3_next;
    pewb_pkg::pewb_mid_t s4_reg, s4_next;

    function automatic logic signed [VD_W-1:0] drag(input logic signed [31:0] v);
        logic signed [VD_P_W-1:0] p;
        p = v * pewb_pkg::DRAG_C;
        p = p + VD_P_W'(pewb_pkg::HALF_L);
        return VD_W'(p >>> F);
    endfunction

    function automatic logic signed [ADT_W-1:0] acc_dt(
        input logic signed [31:0]          a,
        input logic [pewb_pkg::DT_W-1:0]   dt
    );
        logic signed [ADT_P_W-1:0] p;
        p = a * $signed({1'b0, dt});
        p = p + ADT_P_W'(pewb_pkg::HALF_L);
        return ADT_W'(p >>> F);
    endfunction

    function automatic logic signed [VW-1:0] vclamp(input logic signed [SUM_W-1:0] s);
        logic signed [VW-1:0] r;
        if (s > SUM_W'(pewb_pkg::VLIM_P))
        begin
            r = pewb_pkg::VLIM_P;
        end
        else if (s < SUM_W'(pewb_pkg::VLIM_N))
        begin
            r = pewb_pkg::VLIM_N;
        end
        else
        begin
            r = VW'(s);
        end
        return r;
    endfunction

    always_comb
    begin
        // Drag and acceleration products.
        s1_next.valid = in_valid;
        s1_next.pos_x = in_item.pos_x;
        s1_next.pos_y = in_item.pos_y;
        s1_next.vd_x  = drag(in_item.vel_x);
        s1_next.vd_y  = drag(in_item.vel_y);
        s1_next.adt_x = acc_dt(in_item.acc_x, cfg.time_step);
        s1_next.adt_y = acc_dt(in_item.acc_y, cfg.time_step);
        s1_next.last  = in_item.last_particle;

        // Velocity update and clamp.
        s2_next.valid = s1_reg.valid;
        s2_next.pos_x = s1_reg.pos_x;
        s2_next.pos_y = s1_reg.pos_y;
        s2_next.vel_x = vclamp(SUM_W'(s1_reg.vd_x) + SUM_W'(s1_reg.adt_x));
        s2_next.vel_y = vclamp(SUM_W'(s1_reg.vd_y) + SUM_W'(s1_reg.adt_y));
        s2_next.last  = s1_reg.last;

        // Displacement products.
        s3_next.valid = s2_reg.valid;
        s3_next.pos_x = s2_reg.pos_x;
        s3_next.pos_y = s2_reg.pos_y;
        s3_next.vel_x = s2_reg.vel_x;
        s3_next.vel_y = s2_reg.vel_y;
        s3_next.vdt_x = pewb_pkg::fx_vel_dt(s2_reg.vel_x, cfg.time_step);
        s3_next.vdt_y = pewb_pkg::fx_vel_dt(s2_reg.vel_y, cfg.time_step);
        s3_next.last  = s2_reg.last;

        // Position update with saturation.
        s4_next.valid = s3_reg.valid;
        s4_next.pos_x = pewb_pkg::sat32(33'(s3_reg.pos_x) + 33'(s3_reg.vdt_x));
        s4_next.pos_y = pewb_pkg::sat32(33'(s3_reg.pos_y) + 33'(s3_reg.vdt_y));
        s4_next.vel_x = s3_reg.vel_x;
        s4_next.vel_y = s3_reg.vel_y;
        s4_next.last  = s3_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
        end
        else if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    assign mid = s4_reg;

endmodule

### src/pewb_wall.sv
module pewb_wall (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  pewb_pkg::pewb_mid_t  mid,
    input  pewb_pkg::pewb_cfg_t  cfg,
    output pewb_pkg::pewb_wall_t wout
);

    localparam int F      = pewb_pkg::FRAC_BITS;
    localparam int VW     = pewb_pkg::VEL_W;
    localparam int DMP_W  = VW + F + 2;
    localparam int NWALLS = 4;

    // Walls are applied in this order, one stage each.
    localparam int WALL_RIGHT  = 0;
    localparam int WALL_LEFT   = 1;
    localparam int WALL_BOTTOM = 2;
    localparam int WALL_TOP    = 3;

    typedef struct packed {
        logic                  valid;
        logic signed [31:0]    pos_x;
        logic signed [31:0]    pos_y;
        logic signed [VW-1:0]  vel_x;
        logic signed [VW-1:0]  vel_y;
        logic [NWALLS-1:0]     hits;
        logic                  last;
    } wst_t;

    wst_t w_reg  [0:NWALLS];
    wst_t w_next [0:NWALLS];

    logic signed [32:0] px_hi, px_lo, py_hi, py_lo;
    logic signed [32:0] margin_s;

    function automatic logic signed [VW-1:0] vabs(input logic signed [VW-1:0] v);
        return v[VW-1] ? -v : v;
    endfunction

    function automatic logic signed [VW-1:0] damp(input logic signed [VW-1:0] v);
        logic signed [DMP_W-1:0] p;
        p = v * pewb_pkg::DAMP_C;
        p = p + DMP_W'(pewb_pkg::HALF_L);
        return VW'(p >>> F);
    endfunction

    always_comb
    begin
        logic signed [VW-1:0] tx;
        logic signed [VW-1:0] ty;

        // Wall tests are exact at 33 bits.
        margin_s = $signed({2'b00, cfg.wall_margin});
        px_hi    = 33'(mid.pos_x) + margin_s;
        px_lo    = 33'(mid.pos_x) - margin_s;
        py_hi    = 33'(mid.pos_y) + margin_s;
        py_lo    = 33'(mid.pos_y) - margin_s;

        w_next[0].valid              = mid.valid;
        w_next[0].pos_x              = mid.pos_x;
        w_next[0].pos_y              = mid.pos_y;
        w_next[0].vel_x              = mid.vel_x;
        w_next[0].vel_y              = mid.vel_y;
        w_next[0].last               = mid.last;
        w_next[0].hits[WALL_RIGHT]   = px_hi > 33'(cfg.box_high_x);
        w_next[0].hits[WALL_LEFT]    = px_lo < 33'(cfg.box_low_x);
        w_next[0].hits[WALL_BOTTOM]  = py_lo < 33'(cfg.box_low_y);
        w_next[0].hits[WALL_TOP]     = py_hi > 33'(cfg.box_high_y);

        for (int k = 0; k < NWALLS; k++)
        begin
            w_next[k+1] = w_reg[k];
            tx = w_reg[k].vel_x;
            ty = w_reg[k].vel_y;
            unique case (k)
                WALL_RIGHT:  tx = -vabs(w_reg[k].vel_x);
                WALL_LEFT:   tx = vabs(w_reg[k].vel_x);
                WALL_BOTTOM: ty = vabs(w_reg[k].vel_y);
                default:     ty = -vabs(w_reg[k].vel_y);
            endcase
            if (w_reg[k].hits[k])
            begin
                w_next[k+1].vel_x = damp(tx);
                w_next[k+1].vel_y = damp(ty);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '{default: '0};
        end
        else if (en)
        begin
            w_reg <= w_next;
        end
    end

    assign wout.valid = w_reg[NWALLS].valid;
    assign wout.pos_x = w_reg[NWALLS].pos_x;
    assign wout.pos_y = w_reg[NWALLS].pos_y;
    assign wout.vel_x = w_reg[NWALLS].vel_x;
    assign wout.vel_y = w_reg[NWALLS].vel_y;
    assign wout.hit   = |w_reg[NWALLS].hits;
    assign wout.last  = w_reg[NWALLS].last;

`ifndef ASSERT_OFF
    // A right wall hit always leaves the x velocity pointing inward.
    a_right_inward: assert property (@(posedge clk) disable iff (!rst_n)
        en && w_reg[WALL_RIGHT].valid && w_reg[WALL_RIGHT].hits[WALL_RIGHT]
        |=> w_reg[WALL_RIGHT+1].vel_x <= 0)
        else $error("right wall hit left x velocity outward");

    // The top wall, when not hit, passes the y velocity through untouched.
    a_no_hit_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        en && !w_reg[WALL_TOP].hits[WALL_TOP]
        |=> w_reg[WALL_TOP+1].vel_y == $past(w_reg[WALL_TOP].vel_y))
        else $error("velocity changed without a top wall hit");

    // Damping never pushes the velocity past the limit.
    a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
        w_reg[NWALLS].valid
        |-> w_reg[NWALLS].vel_x <= pewb_pkg::VLIM_P && w_reg[NWALLS].vel_x >= pewb_pkg::VLIM_N
            && w_reg[NWALLS].vel_y <= pewb_pkg::VLIM_P
            && w_reg[NWALLS].vel_y >= pewb_pkg::VLIM_N)
        else $error("velocity left the clamp range after damping");

    // While the pipeline is held, the last wall stage keeps its item.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(w_reg[NWALLS]))
        else $error("wall stage changed while held");
`endif

endmodule

### src/pewb_nudge.sv
module pewb_nudge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  pewb_pkg::pewb_wall_t win,
    input  logic [pewb_pkg::DT_W-1:0] time_step,
    output logic                 res_valid,
    output pewb_pkg::pewb_out_t  res_item
);

    localparam int VW    = pewb_pkg::VEL_W;
    localparam int VDT_W = pewb_pkg::VDT_W;

    typedef struct packed {
        logic                    valid;
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic signed [VW-1:0]    vel_x;
        logic signed [VW-1:0]    vel_y;
        logic signed [VDT_W-1:0] vdt_x;
        logic signed [VDT_W-1:0] vdt_y;
        logic                    hit;
        logic                    last;
    } n1_t;

    n1_t                 n1_reg, n1_next;
    logic                out_valid_reg, out_valid_next;
    pewb_pkg::pewb_out_t out_reg, out_next;

    // Sign-extend or truncate to the output velocity width.
    function automatic logic signed [pewb_pkg::VOUT_W-1:0] vel_out(
        input logic signed [VW-1:0] v
    );
        longint t;
        t = longint'(v);
        return t[pewb_pkg::VOUT_W-1:0];
    endfunction

    always_comb
    begin
        n1_next.valid = win.valid;
        n1_next.pos_x = win.pos_x;
        n1_next.pos_y = win.pos_y;
        n1_next.vel_x = win.vel_x;
        n1_next.vel_y = win.vel_y;
        n1_next.vdt_x = pewb_pkg::fx_vel_dt(win.vel_x, time_step);
        n1_next.vdt_y = pewb_pkg::fx_vel_dt(win.vel_y, time_step);
        n1_next.hit   = win.hit;
        n1_next.last  = win.last;

        // Damping only shrinks the velocity, so no second clamp is needed.
        out_valid_next     = n1_reg.valid;
        out_next.new_vel_x = vel_out(n1_reg.vel_x);
        out_next.new_vel_y = vel_out(n1_reg.vel_y);
        out_next.hit_wall  = n1_reg.hit;
        out_next.pass_done = n1_reg.last;
        if (n1_reg.hit)
        begin
            out_next.new_pos_x = pewb_pkg::sat32(33'(n1_reg.pos_x) + 33'(n1_reg.vdt_x));
            out_next.new_pos_y = pewb_pkg::sat32(33'(n1_reg.pos_y) + 33'(n1_reg.vdt_y));
        end
        else
        begin
            out_next.new_pos_x = n1_reg.pos_x;
            out_next.new_pos_y = n1_reg.pos_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (en)
        begin
            n1_reg        <= n1_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;

endmodule

### src/particle_euler_step_with_wall_bounce_top.sv
// One 2D particle update per item in signed Q16.16: drag on the velocity, a symplectic
// Euler step with the velocity clamped to plus or minus 100 and the position saturated,
// then reflection and damping by 0.9 at each of the right, left, bottom and top walls
// whose test holds, and a second position step when any wall was hit. A new item is
// taken in every cycle while particle_stall is low. The stages are four stages of
// integration (two multiplier stages and two add stages), one stage of wall tests,
// one damping multiplier stage per wall, and a multiply and an add stage for the
// final nudge, the last of which is the output register. The whole pipeline advances
// together, so particle_stall is raised exactly while a result sits in the output
// register and result_stall is high; nothing is dropped or repeated across a stall.
// The user writes the config registers via cfg_we, cfg_index and cfg_data only while
// no item is in flight, not enforced by the block; an unknown index is ignored.
module particle_euler_step_with_wall_bounce_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          particle_valid,
    output logic                          particle_stall,
    input  pewb_pkg::pewb_in_t            particle,
    output logic                          result_valid,
    input  logic                          result_stall,
    output pewb_pkg::pewb_out_t           result,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [pewb_pkg::CFG_W-1:0]    cfg_data
);

    pewb_pkg::pewb_cfg_t  cfg_reg;
    pewb_pkg::pewb_mid_t  mid;
    pewb_pkg::pewb_wall_t wall;
    logic                 en;

    // The pipeline moves whenever the output register is free or being emptied.
    assign en             = !(result_valid && result_stall);
    assign particle_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step   <= pewb_pkg::TIME_STEP_RST;
            cfg_reg.wall_margin <= pewb_pkg::WALL_MARGIN_RST;
            cfg_reg.box_low_x   <= pewb_pkg::BOX_LOW_RST;
            cfg_reg.box_low_y   <= pewb_pkg::BOX_LOW_RST;
            cfg_reg.box_high_x  <= pewb_pkg::BOX_HIGH_RST;
            cfg_reg.box_high_y  <= pewb_pkg::BOX_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pewb_pkg::REG_TIME_STEP:
                    cfg_reg.time_step <= cfg_data[pewb_pkg::DT_W-1:0];
                pewb_pkg::REG_WALL_MARGIN:
                    cfg_reg.wall_margin <= cfg_data[pewb_pkg::MARGIN_W-1:0];
                pewb_pkg::REG_BOX_LOW_X:  cfg_reg.box_low_x  <= $signed(cfg_data);
                pewb_pkg::REG_BOX_LOW_Y:  cfg_reg.box_low_y  <= $signed(cfg_data);
                pewb_pkg::REG_BOX_HIGH_X: cfg_reg.box_high_x <= $signed(cfg_data);
                pewb_pkg::REG_BOX_HIGH_Y: cfg_reg.box_high_y <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // Drag, velocity step and clamp, position step.
    pewb_integrate u_integrate (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (particle_valid),
        .in_item  (particle),
        .cfg      (cfg_reg),
        .mid      (mid)
    );

    // Wall tests and up to four reflections.
    pewb_wall u_wall (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .mid   (mid),
        .cfg   (cfg_reg),
        .wout  (wall)
    );

    // Second position step after a bounce, and the output register.
    pewb_nudge u_nudge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .win       (wall),
        .time_step (cfg_reg.time_step),
        .res_valid (result_valid),
        .res_item  (result)
    );

endmodule

### verif/tb_particle_euler_step_with_wall_bounce_top.sv
`timescale 1ns / 100ps

// Testbench for the particle update pipeline.
// Each accepted particle is run through a predictor written here in 64 bit
// integer arithmetic. The predictor damps the velocity, integrates it,
// reflects it at the walls and applies the final nudge. The predicted update
// is queued, and every result the block hands over is checked field by field
// against the oldest entry of that queue.
// Stimulus is produced by one test task for each thing under test. The tasks
// run in turn from a single initial block and share the task that offers one
// item. A separate process checks each result as it leaves the block.
module tb_particle_euler_step_with_wall_bounce_top;

    import pewb_pkg::*;

    // Eleven register stages from input to output; the drain pause adds a little to this.
    localparam int LATENCY     = 11;
    localparam int CYCLE_LIMIT = 600000;

    localparam int     FRAC    = FRAC_BITS;
    localparam longint ONE_Q   = longint'(1) << FRAC;
    localparam longint HALF_Q  = ONE_Q / 2;
    localparam longint DRAG_Q  = (ONE_Q * 9999 + 5000) / 10000;
    localparam longint DAMP_Q  = (ONE_Q * 9 + 5) / 10;
    localparam longint VLIM_Q  = ONE_Q * 100;
    localparam longint POS_MIN = -(longint'(1) << 31);
    localparam longint POS_MAX = (longint'(1) << 31) - 1;

    // The index field is three bits wide, so two indexes select no register at all.
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        particle_valid = 1'b0;
    logic        particle_stall;
    pewb_in_t    particle       = '0;
    logic        result_valid;
    logic        result_stall   = 1'b0;
    pewb_out_t   result;
    logic        cfg_we         = 1'b0;
    logic [2:0]  cfg_index      = '0;
    logic [CFG_W-1:0] cfg_data  = '0;

    // This is the testbench's own copy of the registers, kept in step with every write.
    // It starts at the documented reset values.
    pewb_cfg_t live_cfg = '{time_step: 17'd655, wall_margin: 31'd65536,
                            box_low_x: 32'sd0, box_low_y: 32'sd0,
                            box_high_x: 32'sd6553600, box_high_y: 32'sd6553600};

    // These are the updates predicted for accepted particles, oldest first.
    pewb_out_t predicted_updates[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int mismatches     = 0;
    int sent_count     = 0;
    int checked_count  = 0;
    int bounce_count   = 0;
    int pass_end_count = 0;
    int setting_count  = 0;

    particle_euler_step_with_wall_bounce_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .particle_valid (particle_valid),
        .particle_stall (particle_stall),
        .particle       (particle),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // -------------------------------------------------------------------------
    // Predictor
    // -------------------------------------------------------------------------

    // The product is exact, then rounded half up to FRAC fraction bits. The shift is
    // arithmetic, so negative products round towards minus infinity after the bias.
    function automatic longint q_mul(longint a, longint b);
        return (a * b + HALF_Q) >>> FRAC;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Every wall that is struck scales both velocity components by 0.9.
    function automatic void damp_both(inout longint vx, inout longint vy);
        vx = q_mul(vx, DAMP_Q);
        vy = q_mul(vy, DAMP_Q);
    endfunction

    function automatic pewb_out_t predict_step(pewb_in_t p, pewb_cfg_t c);
        longint    dt;
        longint    m;
        longint    px;
        longint    py;
        longint    vx;
        longint    vy;
        bit        bounced;
        pewb_out_t r;
        dt      = longint'(c.time_step);
        m       = longint'(c.wall_margin);
        px      = longint'(p.pos_x);
        py      = longint'(p.pos_y);
        bounced = 1'b0;

        vx = clip(q_mul(longint'(p.vel_x), DRAG_Q) + q_mul(longint'(p.acc_x), dt),
                  -VLIM_Q, VLIM_Q);
        vy = clip(q_mul(longint'(p.vel_y), DRAG_Q) + q_mul(longint'(p.acc_y), dt),
                  -VLIM_Q, VLIM_Q);
        px = clip(px + q_mul(vx, dt), POS_MIN, POS_MAX);
        py = clip(py + q_mul(vy, dt), POS_MIN, POS_MAX);

        // The walls are tested in a fixed order: right, left, bottom, then top.
        if (px + m > longint'(c.box_high_x))
        begin
            bounced = 1'b1;
            vx = -magnitude(vx);
            damp_both(vx, vy);
        end
        if (px - m < longint'(c.box_low_x))
        begin
            bounced = 1'b1;
            vx = magnitude(vx);
            damp_both(vx, vy);
        end
        if (py - m < longint'(c.box_low_y))
        begin
            bounced = 1'b1;
            vy = magnitude(vy);
            damp_both(vx, vy);
        end
        if (py + m > longint'(c.box_high_y))
        begin
            bounced = 1'b1;
            vy = -magnitude(vy);
            damp_both(vx, vy);
        end
        if (bounced)
        begin
            px = clip(px + q_mul(vx, dt), POS_MIN, POS_MAX);
            py = clip(py + q_mul(vy, dt), POS_MIN, POS_MAX);
            vx = clip(vx, -VLIM_Q, VLIM_Q);
            vy = clip(vy, -VLIM_Q, VLIM_Q);
        end

        r.new_pos_x = px[31:0];
        r.new_pos_y = py[31:0];
        r.new_vel_x = vx[VOUT_W-1:0];
        r.new_vel_y = vy[VOUT_W-1:0];
        r.hit_wall  = bounced;
        r.pass_done = p.last_particle;
        return r;
    endfunction

    // -------------------------------------------------------------------------
    // Stimulus helpers
    // -------------------------------------------------------------------------

    function automatic logic signed [31:0] q(int whole);
        return 32'(longint'(whole) * ONE_Q);
    endfunction

    function automatic pewb_in_t make_particle(logic signed [31:0] px, logic signed [31:0] py,
                                               logic signed [31:0] vx, logic signed [31:0] vy,
                                               logic signed [31:0] ax, logic signed [31:0] ay,
                                               logic last);
        pewb_in_t p;
        p.pos_x = px;
        p.pos_y = py;
        p.vel_x = vx;
        p.vel_y = vy;
        p.acc_x = ax;
        p.acc_y = ay;
        p.last_particle = last;
        return p;
    endfunction

    // Returns a coordinate within 4 units of a point one margin inside either wall,
    // of the point one margin outside the low wall, or of the centre of the span.
    function automatic logic signed [31:0] coord_near(logic signed [31:0] lo,
                                                      logic signed [31:0] hi,
                                                      logic [MARGIN_W-1:0] m);
        longint base;
        case ($urandom_range(3))
            0:       base = longint'(lo) + longint'(m);
            1:       base = longint'(hi) - longint'(m);
            2:       base = (longint'(lo) + longint'(hi)) / 2;
            default: base = longint'(lo) - longint'(m);
        endcase
        base = base + longint'($urandom_range(0, 8 << FRAC)) - (4 << FRAC);
        return 32'(clip(base, POS_MIN, POS_MAX));
    endfunction

    // Most particles sit near the walls of the current box with plausible motion,
    // so that the bounce logic is exercised hard. The rest carry raw random bits.
    function automatic pewb_in_t random_particle();
        pewb_in_t p;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom)};
        if ($urandom_range(99) < 70)
        begin
            p.pos_x = coord_near(live_cfg.box_low_x, live_cfg.box_high_x, live_cfg.wall_margin);
            p.pos_y = coord_near(live_cfg.box_low_y, live_cfg.box_high_y, live_cfg.wall_margin);
            p.vel_x = 32'(longint'($urandom_range(0, 260 << FRAC)) - (130 << FRAC));
            p.vel_y = 32'(longint'($urandom_range(0, 260 << FRAC)) - (130 << FRAC));
            p.acc_x = 32'(longint'($urandom_range(0, 4000 << FRAC)) - (2000 << FRAC));
            p.acc_y = 32'(longint'($urandom_range(0, 4000 << FRAC)) - (2000 << FRAC));
            p.last_particle = ($urandom_range(15) == 0);
        end
        return p;
    endfunction

    // This task offers one item and returns once it has been accepted. Idle cycles
    // come first, so the gaps land on whatever the pipeline happens to be doing.
    // Valid is never lowered and raised again within the same clock edge.
    task automatic send_particle(input pewb_in_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            particle_valid <= 1'b0;
            @(posedge clk);
        end
        particle       <= p;
        particle_valid <= 1'b1;
        @(posedge clk);
        while (particle_stall)
            @(posedge clk);
        predicted_updates.push_back(predict_step(p, live_cfg));
        sent_count++;
    endtask

    // Every particle produces exactly one result, so an empty queue means the pipe
    // is empty. The pause after it gives the output register time to settle.
    task automatic wait_idle();
        particle_valid <= 1'b0;
        while (predicted_updates.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TIME_STEP:   live_cfg.time_step   = data[DT_W-1:0];
            REG_WALL_MARGIN: live_cfg.wall_margin = data[MARGIN_W-1:0];
            REG_BOX_LOW_X:   live_cfg.box_low_x   = data;
            REG_BOX_LOW_Y:   live_cfg.box_low_y   = data;
            REG_BOX_HIGH_X:  live_cfg.box_high_x  = data;
            REG_BOX_HIGH_Y:  live_cfg.box_high_y  = data;
            default:         ;
        endcase
    endtask

    task automatic program_setup(input logic [31:0] dt, input logic [31:0] margin,
                                 input logic [31:0] lx, input logic [31:0] ly,
                                 input logic [31:0] hx, input logic [31:0] hy);
        wait_idle();
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_WALL_MARGIN, margin);
        write_reg(REG_BOX_LOW_X, lx);
        write_reg(REG_BOX_LOW_Y, ly);
        write_reg(REG_BOX_HIGH_X, hx);
        write_reg(REG_BOX_HIGH_Y, hy);
        setting_count++;
    endtask

    // The bits above each narrow register are filled at random, as the block is
    // expected to drop them.
    task automatic program_random_setup();
        logic [31:0] dt;
        logic [31:0] margin;
        logic [31:0] lx;
        logic [31:0] ly;
        logic [31:0] hx;
        logic [31:0] hy;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 10)
            dt = 32'd0;
        else if (pick < 20)
            dt = 32'h1FFFF;
        else if (pick < 25)
            dt = 32'h10000;
        else
            dt = $urandom_range(1, 6553);
        dt = dt | ($urandom & 32'hFFFE_0000);

        pick = $urandom_range(99);
        if (pick < 10)
            margin = 32'd0;
        else if (pick < 18)
            margin = 32'h7FFF_FFFF;
        else if (pick < 25)
            margin = $urandom;
        else
            margin = $urandom_range(0, 4 << FRAC);
        margin[31] = 1'($urandom);

        pick = $urandom_range(99);
        lx = 32'($urandom_range(0, 2000 << FRAC)) - 32'(1000 << FRAC);
        ly = 32'($urandom_range(0, 2000 << FRAC)) - 32'(1000 << FRAC);
        if (pick < 10)
        begin
            lx = 32'h8000_0000;
            ly = 32'h8000_0000;
            hx = 32'h7FFF_FFFF;
            hy = 32'h7FFF_FFFF;
        end
        else if (pick < 20)
        begin
            lx = $urandom;
            ly = $urandom;
            hx = $urandom;
            hy = $urandom;
        end
        else if (pick < 28)
        begin
            // An inverted box: the high corner lies below the low one.
            hx = lx - 32'($urandom_range(0, 20 << FRAC));
            hy = ly - 32'($urandom_range(0, 20 << FRAC));
        end
        else
        begin
            hx = lx + 32'($urandom_range(0, 200 << FRAC));
            hy = ly + 32'($urandom_range(0, 200 << FRAC));
        end
        program_setup(dt, margin, lx, ly, hx, hy);
    endtask

    // -------------------------------------------------------------------------
    // Tests
    // -------------------------------------------------------------------------

    // This test runs under the reset configuration, with no register writes: the box
    // spans 0 to 100, the radius is 1 and the step is 0.01. It strikes each wall in
    // turn and drives every input field to its extremes.
    task automatic check_reset_values();
        send_particle(make_particle(q(0), q(0), q(0), q(0), q(0), q(0), 1'b0));
        send_particle(make_particle(q(50), q(50), q(0), q(0), q(0), q(0), 1'b0));
        send_particle(make_particle(q(99) + 32768, q(50), q(10), q(3), q(0), q(0), 1'b0));
        send_particle(make_particle(q(0) + 32768, q(50), -q(10), q(3), q(0), q(0), 1'b0));
        send_particle(make_particle(q(50), q(0) + 32768, q(2), -q(10), q(0), q(0), 1'b0));
        send_particle(make_particle(q(50), q(99) + 32768, q(2), q(10), q(0), q(0), 1'b0));
        send_particle(make_particle(q(99) + 32768, q(99) + 32768, q(40), q(40), q(5), q(5),
                                    1'b1));
        // Velocities far beyond the limit, in both directions.
        send_particle(make_particle(q(50), q(50), 32'sh7FFF_FFFF, 32'sh8000_0000, q(0), q(0),
                                    1'b1));
        send_particle(make_particle(q(50), q(50), q(0), q(0), 32'sh7FFF_FFFF, 32'sh8000_0000,
                                    1'b0));
        send_particle(make_particle(32'sh7FFF_FFFF, 32'sh8000_0000, q(100), -q(100),
                                    32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0));
        send_particle(make_particle(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                    32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1));
        send_particle(make_particle(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b1));
    endtask

    // This test puts each register at its extremes: a zero step, the largest step and
    // a step of exactly one. It also covers a radius that touches every wall, a box
    // spanning the whole range, an inverted box, a box with no width, and writes to
    // indexes that select no register.
    task automatic check_register_extremes();
        program_setup(32'hFFFE_0000, 32'h8000_0001, 32'd0, 32'd0, q(100), q(100));
        send_particle(make_particle(q(50), q(50), q(7), -q(7), q(900), -q(900), 1'b0));
        program_setup(32'hFFFF_FFFF, 32'd65536, 32'd0, 32'd0, q(100), q(100));
        send_particle(make_particle(q(50), q(98), q(90), q(90), 32'sh7FFF_FFFF,
                                    32'sh8000_0000, 1'b0));
        program_setup(32'h0001_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, q(100), q(100));
        send_particle(make_particle(q(50), q(50), q(20), -q(30), q(1), q(1), 1'b1));
        program_setup(32'h0001_0000, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF);
        send_particle(make_particle(32'sh7FFF_0000, 32'sh8000_FFFF, q(100), -q(100), q(0),
                                    q(0), 1'b0));
        program_setup(32'd655, 32'd0, q(100), q(100), q(0), q(0));
        send_particle(make_particle(q(50), q(50), q(5), -q(5), q(0), q(0), 1'b0));
        program_setup(32'd655, 32'd0, q(0), q(0), q(0), q(0));
        send_particle(make_particle(q(0), q(0), q(0), q(0), q(0), q(0), 1'b0));
        send_particle(make_particle(q(1), -q(1), q(0), q(0), q(0), q(0), 1'b1));
        wait_idle();
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        send_particle(make_particle(q(1), -q(1), q(3), q(3), q(0), q(0), 1'b0));
    endtask

    // This test runs one idling pattern over two random register settings.
    task automatic run_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int count);
        for (int s = 0; s < 2; s++)
        begin
            program_random_setup();
            send_idle_pct  = sender_pct;
            recv_stall_pct = receiver_pct;
            for (int i = 0; i < count / 2; i++)
                send_particle(random_particle());
        end
    endtask

    // In this test the receiver refuses results for a long stretch while the sender
    // keeps offering. The pipeline fills up and must push back on its input.
    task automatic check_output_holdoff();
        program_random_setup();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        for (int i = 0; i < 80; i++)
            send_particle(random_particle());
    endtask

    // In this test the sender stops until every outstanding result has arrived, then
    // resumes into an empty pipeline.
    task automatic check_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 20;
        for (int i = 0; i < 20; i++)
            send_particle(random_particle());
        particle_valid <= 1'b0;
        while (predicted_updates.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 20; i++)
            send_particle(random_particle());
    endtask

    // -------------------------------------------------------------------------
    // Receiver, checker and watchdog
    // -------------------------------------------------------------------------

    // This process drives the receiver's stall. A pending hold-off keeps it high for
    // that many cycles. Otherwise the stall is drawn at random, at the rate of the
    // current phase.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                     $time, field, $signed(want), want, $signed(got), got);
        end
    endtask

    // Outputs are sampled at the clock edge, before this edge's updates land. The
    // result seen here is therefore the one the handshake transferred.
    always @(posedge clk)
    begin
        pewb_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (predicted_updates.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing outstanding, expected none, got %h",
                         $time, result);
            end
            else
            begin
                want = predicted_updates.pop_front();
                compare_field("new_pos_x", want.new_pos_x, result.new_pos_x);
                compare_field("new_pos_y", want.new_pos_y, result.new_pos_y);
                compare_field("new_vel_x", want.new_vel_x, result.new_vel_x);
                compare_field("new_vel_y", want.new_vel_y, result.new_vel_y);
                compare_field("hit_wall", want.hit_wall, result.hit_wall);
                compare_field("pass_done", want.pass_done, result.pass_done);
                checked_count++;
                bounce_count   += want.hit_wall;
                pass_end_count += want.pass_done;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, predicted_updates.size());
            $display("FAIL particle_euler_step_with_wall_bounce_top");
            $finish;
        end
    end

    // -------------------------------------------------------------------------
    // Sequence
    // -------------------------------------------------------------------------

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reset_values();
        check_register_extremes();
        run_random_traffic(0, 0, 500);
        run_random_traffic(51, 0, 500);
        run_random_traffic(0, 51, 500);
        run_random_traffic(37, 37, 500);
        check_output_holdoff();
        check_drain_pause();

        // Any result still missing keeps the queue from emptying, and the watchdog reports it.
        particle_valid <= 1'b0;
        while (predicted_updates.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        mismatches += predicted_updates.size();

        $display("Checked %0d of %0d particles over %0d register settings and four idling patterns,",
                 checked_count, sent_count, setting_count);
        $display("with %0d wall bounces, %0d end-of-pass marks and one long output hold-off.",
                 bounce_count, pass_end_count);
        if (mismatches == 0)
        begin
            $display("PASS particle_euler_step_with_wall_bounce_top");
        end
        else
        begin
            $display("%0d mismatches found.", mismatches);
            $display("FAIL particle_euler_step_with_wall_bounce_top");
        end
        $finish;
    end

endmodule
